// File: src/running_min_max_mean_macros.svh
// -----------------------------------------------------------------------------
// running_min_max_mean_macros: assertion helpers for the running statistics block
// concurrent checks sampled on clk_i and disabled while rst_ni is low
// -----------------------------------------------------------------------------
`ifndef RUNNING_MIN_MAX_MEAN_MACROS_SVH
`define RUNNING_MIN_MAX_MEAN_MACROS_SVH

// same-cycle implication
`define RMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rmm_pkg.sv
// -----------------------------------------------------------------------------
// rmm_pkg: shared types and widths
// field widths and the running state record of the statistics block
// -----------------------------------------------------------------------------
package rmm_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned MEAN_W   = 40;

  // running state of the open set
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] min_v;
    logic signed [SAMPLE_W-1:0] max_v;
    logic signed [SUM_W-1:0]    sum;
    logic        [CNT_W-1:0]    cnt;
    logic                       ovf;
  } acc_state_t;

endpackage

// File: src/running_min_max_mean.sv
// -----------------------------------------------------------------------------
// running_min_max_mean: per-set minimum, maximum, count and fixed-point mean
// takes signed samples, one result item per set on the sample flagged last
// -----------------------------------------------------------------------------
// usage
// - input channel: sample_i and last_i under in_valid_i / in_stall_o; an item
//   is taken at a rising edge with in_valid_i high and in_stall_o low
// - output channel: min, max, mean, count and too_long under out_valid_o /
//   out_stall_i; the result item holds steady while stalled
// - an item without last is folded into the running state as it is taken, so
//   such items go at one per cycle while in_stall_o is low
// - an item with last starts the mean: a load state starts the divider, which
//   gives one quotient bit per cycle over 48 + FRAC_BITS bits; its registered
//   done moves the sequencer to wait, and the mean is saturated and registered
//   once the result register is free; in_stall_o is high through all of it,
//   so the input stays stalled until the mean goes into the result register
// - the result register parts the two sides: samples of the next set are
//   taken while the previous result still waits; a finished mean waits in the
//   divider until the result register is free
// - samples past min(MAX_COUNT, 65535) only set too_long
// - reset clears the running state, the sequencer and out_valid_o
// -----------------------------------------------------------------------------
`include "running_min_max_mean_macros.svh"

module running_min_max_mean #(
  parameter int unsigned MAX_COUNT = 65535,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [rmm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [rmm_pkg::SAMPLE_W-1:0] min_value_o,
  output logic signed [rmm_pkg::SAMPLE_W-1:0] max_value_o,
  output logic signed [rmm_pkg::MEAN_W-1:0]   mean_fixed_o,
  output logic        [rmm_pkg::CNT_W-1:0]    sample_count_o,
  output logic                                too_long_o
);
  import rmm_pkg::*;

  // count limit, capped so it fits the count field
  localparam int unsigned LIMIT_INT = (MAX_COUNT < 65535) ? MAX_COUNT : 65535;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LIMIT_INT);
  // dividend is the sum magnitude scaled by the fraction bits
  localparam int unsigned DW = SUM_W + FRAC_BITS;
  localparam logic [DW-1:0] NEG_MAG = DW'(1) << (MEAN_W - 1);
  localparam logic [DW-1:0] POS_MAX = NEG_MAG - DW'(1);

  typedef enum logic [1:0] {
    S_ACC,   // folding samples
    S_LOAD,  // start the divider on the closed set
    S_DIV,   // divider iterating
    S_WAIT   // mean ready, waiting for the result register
  } state_e;

  state_e     state_q;
  acc_state_t acc;
  logic       in_acc;
  logic       div_done;
  logic [DW-1:0] quot;
  logic [SUM_W-1:0] sum_mag;
  logic [DW-1:0]    dividend;
  logic [DW-1:0]    quot_sat;
  logic signed [MEAN_W-1:0] mean_d;
  logic       load_out;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] min_q;
  logic signed [SAMPLE_W-1:0] max_q;
  logic signed [MEAN_W-1:0]   mean_q;
  logic        [CNT_W-1:0]    cnt_q;
  logic                       too_long_q;

  assign in_stall_o = (state_q != S_ACC);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_out   = (state_q == S_WAIT) && (!out_valid_q || !out_stall_i);

  // running min, max, sum and count
  rmm_acc #(
    .LIMIT (LIMIT)
  ) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (in_acc),
    .clr_i    (load_out),
    .sample_i (sample_i),
    .state_o  (acc)
  );

  // magnitude of the sum; the most negative sum still fits unsigned
  assign sum_mag  = acc.sum[SUM_W-1] ? (SUM_W'(0) - acc.sum) : acc.sum;
  assign dividend = DW'(sum_mag) << FRAC_BITS;

  // divider, one quotient bit a cycle
  rmm_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_LOAD),
    .dividend_i (dividend),
    .divisor_i  (acc.cnt),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // saturate to the mean range and restore the sign
  always_comb begin
    if (acc.sum[SUM_W-1]) begin
      quot_sat = (quot > NEG_MAG) ? NEG_MAG : quot;
      mean_d   = MEAN_W'(0) - quot_sat[MEAN_W-1:0];
    end else begin
      quot_sat = (quot > POS_MAX) ? POS_MAX : quot;
      mean_d   = quot_sat[MEAN_W-1:0];
    end
  end

  // sequencer and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      out_valid_q <= 1'b0;
    end else begin
      // a new result item goes in, or the held one leaves
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_ACC: begin
          if (in_acc && last_i) state_q <= S_LOAD;
        end
        S_LOAD: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (load_out) state_q <= S_ACC;
        end
        default: begin
          state_q <= S_ACC;
        end
      endcase
    end
  end

  // result payload, written only when the register is free
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      min_q      <= acc.min_v;
      max_q      <= acc.max_v;
      mean_q     <= mean_d;
      cnt_q      <= acc.cnt;
      too_long_q <= acc.ovf;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign min_value_o    = min_q;
  assign max_value_o    = max_q;
  assign mean_fixed_o   = mean_q;
  assign sample_count_o = cnt_q;
  assign too_long_o     = too_long_q;

  // checks
  `RMM_ASSERT_NOW(a_cnt_limit, 1'b1, acc.cnt <= LIMIT, "running count above limit")
  `RMM_ASSERT_NEXT(a_last_stalls, in_acc && last_i, in_stall_o, "input open after last item")
  `RMM_ASSERT_NOW(a_cnt_nonzero, $rose(out_valid_o), sample_count_o != '0, "result with no samples")
  `RMM_ASSERT_NOW(a_min_le_max, $rose(out_valid_o), min_value_o <= max_value_o, "min above max")

endmodule

// File: src/rmm_acc.sv
// -----------------------------------------------------------------------------
// rmm_acc: per-sample accumulator
// folds one sample a cycle into min, max, sum and count, flags excess samples
// -----------------------------------------------------------------------------
module rmm_acc #(
  parameter logic [15:0] LIMIT = 16'hFFFF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                upd_i,
  input  logic                                clr_i,
  input  logic signed [rmm_pkg::SAMPLE_W-1:0] sample_i,
  output rmm_pkg::acc_state_t                 state_o
);
  import rmm_pkg::*;

  acc_state_t state_q, state_d;
  logic signed [SUM_W-1:0] sample_x;

  assign sample_x = SUM_W'(sample_i);

  always_comb begin
    state_d = state_q;
    if (clr_i) begin
      state_d = '0;
    end else if (upd_i) begin
      if (state_q.cnt < LIMIT) begin
        if (state_q.cnt == '0) begin
          state_d.min_v = sample_i;
          state_d.max_v = sample_i;
          state_d.sum   = sample_x;
        end else begin
          if (sample_i < state_q.min_v) state_d.min_v = sample_i;
          if (sample_i > state_q.max_v) state_d.max_v = sample_i;
          state_d.sum = state_q.sum + sample_x;
        end
        state_d.cnt = state_q.cnt + CNT_W'(1);
      end else begin
        state_d.ovf = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// File: src/rmm_div.sv
// -----------------------------------------------------------------------------
// rmm_div: iterative unsigned divider
// restoring shift-subtract, one quotient bit per cycle
// -----------------------------------------------------------------------------
module rmm_div #(
  parameter int unsigned DW = 56
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [DW-1:0]                  dividend_i,
  input  logic [rmm_pkg::CNT_W-1:0]      divisor_i,
  output logic                           done_o,
  output logic [DW-1:0]                  quot_o
);
  import rmm_pkg::*;

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0]      dq_q, dq_d;
  logic [CNT_W:0]     rem_q, rem_d;
  logic [CNT_W-1:0]   dsr_q, dsr_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [CNT_W:0]     rem_sh;
  logic [CNT_W+1:0]   diff;
  logic               ge;

  // trial subtract of the shifted partial remainder
  assign rem_sh = {rem_q[CNT_W-1:0], dq_q[DW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
  assign ge     = !diff[CNT_W+1];

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      dq_d  = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = CW'(DW);
    end else if (cnt_q != '0) begin
      dq_d   = {dq_q[DW-2:0], ge};
      rem_d  = ge ? diff[CNT_W:0] : rem_sh;
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule
